// ===== src/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Operation and status codes of the simplex tableau pivot engine.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_PIVOT = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RD    = 13'b0000000000010,
    S_CHK   = 13'b0000000000100,
    S_CPR_A = 13'b0000000001000,
    S_CPR_W = 13'b0000000010000,
    S_CPC_A = 13'b0000000100000,
    S_CPC_W = 13'b0000001000000,
    S_ELD   = 13'b0000010000000,
    S_EMUL  = 13'b0000100000000,
    S_ELOAD = 13'b0001000000000,
    S_EDIV  = 13'b0010000000000,
    S_EWR   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

endpackage

// ===== src/simplex_tableau_pivot.sv =====
// ----------------------------------------------------------------------------
// simplex_tableau_pivot
// Simplex tableau store with a Jordan elimination pivot in Q16.16.
// ----------------------------------------------------------------------------
// One request at a time. A pivot first copies the pivot row and column into
// buffers, then visits every entry in use, and each entry goes through read,
// multiply, load, a bit-serial 64-bit restoring division by the pivot element
// (one quotient bit a cycle) and write back. A new request is taken while the
// previous result waits on the output register.
module simplex_tableau_pivot
  import stp_pkg::*;
#(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[1:0], row_index[5:2], col_index[9:6], entry_value[41:10], zero fill
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_value[31:0], status[33:32], zero fill
  output logic [39:0] out_tdata
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;

  logic [31:0] mem [DEPTH];
  logic [31:0] rowbuf [MAX_COLS];
  logic [31:0] colbuf [MAX_ROWS];

  state_t state_r, state_nxt;
  logic [1:0]  in_func_r;
  logic [4:0]  rows_r, cols_r;
  logic [RW-1:0] i_r, pr_r;
  logic [CW-1:0] j_r, pc_r;
  logic [31:0] mem_q, row_q, col_q;
  logic [31:0] a_r, s_r, d_r;
  logic signed [63:0] prod_r;
  logic [63:0] num_r;
  logic [31:0] rem_r;
  logic        neg_r, sat_r;
  logic [5:0]  cnt_r;
  logic [31:0] res_val_r;
  logic [1:0]  res_st_r;
  logic        out_valid_r;
  logic [31:0] out_val_r;
  logic [1:0]  out_st_r;

  logic [1:0]  in_func;
  logic [3:0]  in_row, in_col;
  logic [31:0] in_val;
  logic [8:0]  nr, nc;
  logic        in_acc, out_range;
  logic [AW-1:0] addr, in_addr;
  logic        we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata;
  logic        is_r, is_c, last_j, last_i;
  logic signed [63:0] numer;
  logic [32:0] dtry;
  logic        dge;
  logic signed [65:0] qsig, v;
  logic [31:0] vclamp;
  logic        vsat;

  assign in_func = in_tdata[1:0];
  assign in_row  = in_tdata[5:2];
  assign in_col  = in_tdata[9:6];
  assign in_val  = in_tdata[41:10];

  assign nr = (9'(rows_r) > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(rows_r);
  assign nc = (9'(cols_r) > 9'(MAX_COLS)) ? 9'(MAX_COLS) : 9'(cols_r);

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_range  = (9'(in_row) >= nr) || (9'(in_col) >= nc);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_st_r, out_val_r};

  assign addr    = AW'(32'(i_r) * MAX_COLS + 32'(j_r));
  assign in_addr = AW'(32'(RW'(in_row)) * MAX_COLS + 32'(CW'(in_col)));

  assign is_r   = (i_r == pr_r);
  assign is_c   = (j_r == pc_r);
  assign last_j = (9'(j_r) == nc - 9'd1);
  assign last_i = (9'(i_r) == nr - 9'd1);

  // Write port: a write request at accept, a pivot result in S_EWR
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = vclamp;
    if (in_acc && in_func == FUNC_WRITE && !out_range) begin
      we    = 1'b1;
      waddr = in_addr;
      wdata = in_val;
    end else if (state_r == S_EWR) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mem_q <= mem[addr];
    row_q <= rowbuf[j_r];
    col_q <= colbuf[i_r];
    if (state_r == S_CPR_W) rowbuf[j_r] <= mem_q;
    if (state_r == S_CPC_W) colbuf[i_r] <= mem_q;
  end

  // Numerator of the division for the entry being visited
  always_comb begin
    if (is_r && is_c) begin
      numer = 64'sd1 <<< (2 * FRAC_BITS);
    end else if (is_r || is_c) begin
      numer = $signed({{32{a_r[31]}}, a_r}) <<< FRAC_BITS;
    end else begin
      numer = prod_r;
    end
  end

  assign dtry = {rem_r, num_r[63]};
  assign dge  = dtry >= {1'b0, d_r};

  always_comb begin
    qsig = neg_r ? -$signed({2'b00, num_r}) : $signed({2'b00, num_r});
    if (is_r) begin
      v = qsig;
    end else if (is_c) begin
      v = -qsig;
    end else begin
      v = $signed({{34{a_r[31]}}, a_r}) - qsig;
    end
    vsat = 1'b1;
    if (v > 66'sd2147483647) begin
      vclamp = 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      vclamp = 32'h8000_0000;
    end else begin
      vclamp = v[31:0];
      vsat   = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_func inside {FUNC_READ, FUNC_PIVOT}) begin
            state_nxt = out_range ? S_OUT : S_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RD:    state_nxt = S_CHK;
      S_CHK: begin
        if (in_func_r == FUNC_PIVOT && mem_q != 32'd0) state_nxt = S_CPR_A;
        else state_nxt = S_OUT;
      end
      S_CPR_A: state_nxt = S_CPR_W;
      S_CPR_W: state_nxt = last_j ? S_CPC_A : S_CPR_A;
      S_CPC_A: state_nxt = S_CPC_W;
      S_CPC_W: state_nxt = last_i ? S_ELD : S_CPC_A;
      S_ELD:   state_nxt = S_EMUL;
      S_EMUL:  state_nxt = S_ELOAD;
      S_ELOAD: state_nxt = S_EDIV;
      S_EDIV:  state_nxt = (cnt_r == 6'd63) ? S_EWR : S_EDIV;
      S_EWR:   state_nxt = (last_i && last_j) ? S_OUT : S_ELD;
      S_OUT:   state_nxt = (!out_valid_r || out_tready) ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= 5'd16;
      cols_r      <= 5'd16;
      out_valid_r <= 1'b0;
      cnt_r       <= 6'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROWS) rows_r <= cfg_data;
        else cols_r <= cfg_data;
      end
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_EDIV) cnt_r <= cnt_r + 6'd1;
      else cnt_r <= 6'd0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          in_func_r <= in_func;
          i_r       <= RW'(in_row);
          j_r       <= CW'(in_col);
          pr_r      <= RW'(in_row);
          pc_r      <= CW'(in_col);
          res_val_r <= 32'd0;
          res_st_r  <= ST_OK;
          sat_r     <= 1'b0;
          if (!(in_func inside {FUNC_WRITE, FUNC_READ, FUNC_PIVOT})) begin
            res_st_r <= ST_OK;
          end else if (out_range) begin
            res_st_r <= ST_RANGE;
          end else if (in_func == FUNC_WRITE) begin
            res_val_r <= in_val;
          end
        end
      end
      S_CHK: begin
        if (in_func_r == FUNC_READ) begin
          res_val_r <= mem_q;
        end else if (mem_q == 32'd0) begin
          res_st_r <= ST_ZERO;
        end else begin
          res_val_r <= mem_q;
          s_r       <= mem_q;
          d_r       <= mem_q[31] ? 32'(-mem_q) : mem_q;
          i_r       <= pr_r;
          j_r       <= '0;
        end
      end
      S_CPR_W: begin
        if (last_j) begin
          j_r <= pc_r;
          i_r <= '0;
        end else begin
          j_r <= j_r + CW'(1);
        end
      end
      S_CPC_W: begin
        if (last_i) begin
          i_r <= '0;
          j_r <= '0;
        end else begin
          i_r <= i_r + RW'(1);
        end
      end
      S_EMUL: begin
        a_r    <= mem_q;
        prod_r <= $signed(col_q) * $signed(row_q);
      end
      S_ELOAD: begin
        num_r <= numer[63] ? 64'(-numer) : 64'(numer);
        neg_r <= numer[63] ^ s_r[31];
        rem_r <= 32'd0;
      end
      S_EDIV: begin
        rem_r <= dge ? 32'(dtry - {1'b0, d_r}) : dtry[31:0];
        num_r <= {num_r[62:0], dge};
      end
      S_EWR: begin
        if (vsat) sat_r <= 1'b1;
        if (last_j) begin
          j_r <= '0;
          i_r <= i_r + RW'(1);
        end else begin
          j_r <= j_r + CW'(1);
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_val_r <= res_val_r;
          out_st_r  <= sat_r ? ST_SAT : res_st_r;
        end
      end
      default: begin
      end
    endcase
  end

  // A result is only loaded from the result state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("result raised outside the result state");

  // Divider counter runs only while dividing
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EDIV) |=> (cnt_r == 6'd0) || (state_r == S_EDIV))
    else $error("divider count left running");

  // Element sweep stays inside the rows and columns in use
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ELD) |-> (9'(i_r) < nr) && (9'(j_r) < nc))
    else $error("pivot sweep out of range");

  // Never divide by a zero pivot
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ELOAD) |-> (d_r != 32'd0))
    else $error("division by zero pivot");

endmodule
